>>> design/rgbblur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgbblur_pkg
// shared types, register codes and divide helpers for the rgb box blur
// ---------------------------------------------------------------------------
package rgbblur_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_SLOTS = 4;
  localparam int CNT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  // red in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // one line store entry: blurred rows r-2 and r-1 of a column
  typedef struct packed {
    rgb_t older;
    rgb_t newer;
  } line_t;

  typedef struct packed {
    logic eof;
    rgb_t rgb;
  } result_t;

  typedef struct packed {
    logic has_col0;
    logic row_end;
    logic row_ge1;
    logic row_eq1;
    logic last_row;
    logic last_col0;
  } flags_t;

  // exact floor(s / 3) for s up to 765
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [9:0] s;
    s = 10'(a) + 10'(b) + 10'(c);
    return div3(s);
  endfunction

  function automatic logic [7:0] third(input logic [7:0] v);
    return div3(10'(v));
  endfunction

  function automatic rgb_t hblur2(input rgb_t a, input rgb_t b);
    rgb_t r;
    r.red   = avg2(a.red, b.red);
    r.green = avg2(a.green, b.green);
    r.blue  = avg2(a.blue, b.blue);
    return r;
  endfunction

  function automatic rgb_t hblur3(input rgb_t a, input rgb_t b, input rgb_t c);
    rgb_t r;
    r.red   = avg3(a.red, b.red, c.red);
    r.green = avg3(a.green, b.green, c.green);
    r.blue  = avg3(a.blue, b.blue, c.blue);
    return r;
  endfunction

  function automatic rgb_t vert2(input rgb_t nw, input rgb_t b);
    rgb_t r;
    r.red   = third(nw.red) + third(b.red);
    r.green = third(nw.green) + third(b.green);
    r.blue  = third(nw.blue) + third(b.blue);
    return r;
  endfunction

  function automatic rgb_t vert3(input rgb_t o, input rgb_t nw, input rgb_t b);
    rgb_t r;
    r.red   = third(o.red) + third(nw.red) + third(b.red);
    r.green = third(o.green) + third(nw.green) + third(b.green);
    r.blue  = third(o.blue) + third(nw.blue) + third(b.blue);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/rgb_separable_box_blur_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_separable_box_blur_3x3
// 3x3 separable box blur over an rgb raster stream, one row of delay
// ---------------------------------------------------------------------------
// usage:
//   s_* takes rgb pixels in raster order, one request per pixel; m_* gives
//   blurred pixels in raster order, output row r-1 leaving while input row r
//   comes in. m_tlast marks the last result caused by one input pixel,
//   m_tuser marks the final pixel of the region.
//   region width and height are set on the cfg port (index 0 width, index 1
//   height); the user sets them only while no request is in flight, which
//   the block does not enforce; out of range values act as 2 or the maximum.
// pipeline and throughput:
//   results pass the vertical stage, then the result queue. while m_tready
//   is high: one pixel per cycle while each yields at most one result; from
//   row 1 on the row end pixel yields two and, in the last row, each pixel
//   after column 0 yields two (four at the last one), one result per cycle
//   on m_*. the line store is one memory of MAX_WIDTH entries with two read
//   ports and one write port; the row end column is written back next cycle.
// reset and stall:
//   rst clears the position, the pipeline and the result queue, and sets
//   the region to 640 x 480; the line store needs no clearing.
//   while m_tready is low the result queue holds, and s_tready drops once a
//   further pixel has results with nowhere to go.
// ---------------------------------------------------------------------------
module rgb_separable_box_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // in_red, in_green, in_blue
  // blurred pixel out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,   // out_red, out_green, out_blue
  output logic                              m_tlast,   // last_of_run
  output logic                              m_tuser,   // end_of_frame
  // configuration
  input  logic                              cfg_write,
  input  logic [rgbblur_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbblur_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // compare width that holds both the register and the maximum
  localparam int DWC  = (COLW + 1 > rgbblur_pkg::CFG_W) ? COLW + 1 : rgbblur_pkg::CFG_W;
  localparam int DWR  = (ROWW + 1 > rgbblur_pkg::CFG_W) ? ROWW + 1 : rgbblur_pkg::CFG_W;

  // configuration registers
  logic [rgbblur_pkg::CFG_W-1:0] region_width;
  logic [rgbblur_pkg::CFG_W-1:0] region_height;

  // clamped last column and last row indexes
  logic [DWC-1:0]  width_ext;
  logic [DWR-1:0]  height_ext;
  logic [COLW-1:0] last_col;
  logic [ROWW-1:0] last_row_idx;

  logic                 accept;
  logic                 s1_valid;
  logic                 s1_adv;
  rgbblur_pkg::flags_t  s1_flags;
  logic [COLW-1:0]      s1_col;
  rgbblur_pkg::rgb_t    s1_blur0;
  rgbblur_pkg::rgb_t    s1_blur1;
  logic [COLW-1:0]      rd_addr0;
  logic [COLW-1:0]      rd_addr1;
  rgbblur_pkg::line_t   line0;
  rgbblur_pkg::line_t   line1;
  logic                 wr_en;
  logic [COLW-1:0]      wr_addr;
  rgbblur_pkg::line_t   wr_data;
  rgbblur_pkg::result_t m_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_width  <= rgbblur_pkg::RESET_WIDTH;
      region_height <= rgbblur_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rgbblur_pkg::REG_REGION_WIDTH:  region_width  <= cfg_data;
        rgbblur_pkg::REG_REGION_HEIGHT: region_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    width_ext  = DWC'(region_width);
    height_ext = DWR'(region_height);
    if (width_ext < DWC'(2)) begin
      last_col = COLW'(1);
    end else if (width_ext > DWC'(MAX_WIDTH)) begin
      last_col = COLW'(MAX_WIDTH - 1);
    end else begin
      last_col = COLW'(width_ext - DWC'(1));
    end
    if (height_ext < DWR'(2)) begin
      last_row_idx = ROWW'(1);
    end else if (height_ext > DWR'(MAX_HEIGHT)) begin
      last_row_idx = ROWW'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = ROWW'(height_ext - DWR'(1));
    end
  end

  // a pixel enters when the vertical stage is empty or moving on
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  rgbblur_hblur #(
    .COLW (COLW),
    .ROWW (ROWW)
  ) u_hblur (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (rgbblur_pkg::rgb_t'(s_tdata)),
    .last_col     (last_col),
    .last_row_idx (last_row_idx),
    .s1_adv       (s1_adv),
    .rd_addr0     (rd_addr0),
    .rd_addr1     (rd_addr1),
    .s1_valid     (s1_valid),
    .s1_flags     (s1_flags),
    .s1_col       (s1_col),
    .s1_blur0     (s1_blur0),
    .s1_blur1     (s1_blur1)
  );

  // line store read on accept, data lines up with the vertical stage
  rgbblur_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_data0 (line0),
    .rd_data1 (line1)
  );

  rgbblur_vsum #(
    .COLW (COLW)
  ) u_vsum (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_flags (s1_flags),
    .s1_col   (s1_col),
    .s1_blur0 (s1_blur0),
    .s1_blur1 (s1_blur1),
    .line0    (line0),
    .line1    (line1),
    .s1_adv   (s1_adv),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_result (m_result),
    .m_last   (m_tlast)
  );

  assign m_tdata = m_result.rgb;
  assign m_tuser = m_result.eof;

endmodule
`default_nettype wire

>>> design/rgbblur_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgbblur_line_mem
// line store: two registered read ports, one write port, write forwarding
// ---------------------------------------------------------------------------
module rgbblur_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rgbblur_pkg::line_t       wr_data,
  output rgbblur_pkg::line_t       rd_data0,
  output rgbblur_pkg::line_t       rd_data1
);

  rgbblur_pkg::line_t mem [DEPTH];
  rgbblur_pkg::line_t rd_q0;
  rgbblur_pkg::line_t rd_q1;
  rgbblur_pkg::line_t fwd_data;
  logic               fwd0;
  logic               fwd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q0    <= mem[rd_addr0];
      rd_q1    <= mem[rd_addr1];
      // a write landing on the same edge wins over the old contents
      fwd0     <= wr_en && (wr_addr == rd_addr0);
      fwd1     <= wr_en && (wr_addr == rd_addr1);
      fwd_data <= wr_data;
    end
  end

  assign rd_data0 = fwd0 ? fwd_data : rd_q0;
  assign rd_data1 = fwd1 ? fwd_data : rd_q1;

endmodule
`default_nettype wire

>>> design/rgbblur_hblur.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgbblur_hblur
// raster position, pixel window and horizontal blur stage
// ---------------------------------------------------------------------------
module rgbblur_hblur #(
  parameter int COLW = 10,
  parameter int ROWW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  rgbblur_pkg::rgb_t   pixel,
  input  logic [COLW-1:0]     last_col,
  input  logic [ROWW-1:0]     last_row_idx,
  input  logic                s1_adv,
  output logic [COLW-1:0]     rd_addr0,
  output logic [COLW-1:0]     rd_addr1,
  output logic                s1_valid,
  output rgbblur_pkg::flags_t s1_flags,
  output logic [COLW-1:0]     s1_col,
  output rgbblur_pkg::rgb_t   s1_blur0,
  output rgbblur_pkg::rgb_t   s1_blur1
);

  logic [COLW-1:0]     column_count;
  logic [ROWW-1:0]     row_count;
  rgbblur_pkg::rgb_t   win_old;
  rgbblur_pkg::rgb_t   win_new;
  rgbblur_pkg::flags_t flags_next;
  rgbblur_pkg::rgb_t   blur0_next;
  rgbblur_pkg::rgb_t   blur1_next;
  logic                row_end;
  logic                last_row;

  always_comb begin
    row_end              = column_count >= last_col;
    last_row             = row_count >= last_row_idx;
    flags_next.has_col0  = column_count != '0;
    flags_next.row_end   = row_end;
    flags_next.row_ge1   = row_count != '0;
    flags_next.row_eq1   = row_count == ROWW'(1);
    flags_next.last_row  = last_row;
    flags_next.last_col0 = (column_count - COLW'(1)) >= last_col;
    // column left of the pixel: two-tap mean at the row start
    blur0_next = (column_count == COLW'(1)) ? rgbblur_pkg::hblur2(win_new, pixel)
                                            : rgbblur_pkg::hblur3(win_old, win_new, pixel);
    // row end column: two-tap mean
    blur1_next = rgbblur_pkg::hblur2(win_new, pixel);
  end

  assign rd_addr0 = column_count - COLW'(1);
  assign rd_addr1 = column_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (row_end) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + ROWW'(1);
        end else begin
          column_count <= column_count + COLW'(1);
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_old  <= win_new;
      win_new  <= pixel;
      s1_flags <= flags_next;
      s1_col   <= column_count;
      s1_blur0 <= blur0_next;
      s1_blur1 <= blur1_next;
    end
  end

endmodule
`default_nettype wire

>>> design/rgbblur_vsum.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgbblur_vsum
// vertical sum, line store write-back and result queue
// ---------------------------------------------------------------------------
module rgbblur_vsum #(
  parameter int COLW = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s1_valid,
  input  rgbblur_pkg::flags_t   s1_flags,
  input  logic [COLW-1:0]       s1_col,
  input  rgbblur_pkg::rgb_t     s1_blur0,
  input  rgbblur_pkg::rgb_t     s1_blur1,
  input  rgbblur_pkg::line_t    line0,
  input  rgbblur_pkg::line_t    line1,
  output logic                  s1_adv,
  output logic                  wr_en,
  output logic [COLW-1:0]       wr_addr,
  output rgbblur_pkg::line_t    wr_data,
  output logic                  m_valid,
  input  logic                  m_ready,
  output rgbblur_pkg::result_t  m_result,
  output logic                  m_last
);

  rgbblur_pkg::rgb_t     first0;
  rgbblur_pkg::rgb_t     second0;
  rgbblur_pkg::rgb_t     first1;
  rgbblur_pkg::rgb_t     second1;
  rgbblur_pkg::result_t  slots [rgbblur_pkg::NUM_SLOTS];
  rgbblur_pkg::result_t  queue [rgbblur_pkg::NUM_SLOTS];
  logic [rgbblur_pkg::CNT_W-1:0] ncol;
  logic [rgbblur_pkg::CNT_W-1:0] n_results;
  logic [rgbblur_pkg::CNT_W-1:0] q_count;
  logic                  out_fire;
  logic                  q_free;
  logic                  load;
  logic                  pend;
  logic [COLW-1:0]       pend_addr;
  rgbblur_pkg::line_t    pend_data;

  always_comb begin
    first0  = s1_flags.row_eq1 ? rgbblur_pkg::vert2(line0.newer, s1_blur0)
                               : rgbblur_pkg::vert3(line0.older, line0.newer, s1_blur0);
    second0 = rgbblur_pkg::vert2(line0.newer, s1_blur0);
    first1  = s1_flags.row_eq1 ? rgbblur_pkg::vert2(line1.newer, s1_blur1)
                               : rgbblur_pkg::vert3(line1.older, line1.newer, s1_blur1);
    second1 = rgbblur_pkg::vert2(line1.newer, s1_blur1);

    ncol = s1_flags.has_col0 ? (s1_flags.row_end ? 3'd2 : 3'd1) : 3'd0;
    if (!s1_flags.row_ge1) begin
      n_results = '0;
    end else if (s1_flags.last_row) begin
      n_results = {ncol[1:0], 1'b0};
    end else begin
      n_results = ncol;
    end

    // last row: each column gives row h-2 and then row h-1
    if (s1_flags.last_row) begin
      slots[0] = '{eof: 1'b0, rgb: first0};
      slots[1] = '{eof: s1_flags.last_col0, rgb: second0};
      slots[2] = '{eof: 1'b0, rgb: first1};
      slots[3] = '{eof: 1'b1, rgb: second1};
    end else begin
      slots[0] = '{eof: 1'b0, rgb: first0};
      slots[1] = '{eof: 1'b0, rgb: first1};
      slots[2] = '{eof: 1'b0, rgb: first1};
      slots[3] = '{eof: 1'b0, rgb: second1};
    end
  end

  assign m_valid  = q_count != '0;
  assign m_result = queue[0];
  assign m_last   = q_count == 3'd1;
  assign out_fire = m_valid && m_ready;
  assign q_free   = (q_count == '0) || ((q_count == 3'd1) && out_fire);
  assign s1_adv   = s1_valid && ((n_results == '0) || q_free);
  assign load     = s1_adv && (n_results != '0);

  // write port: the row end column goes in the cycle after its neighbor
  always_comb begin
    priority if (pend) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = pend_data;
    end else begin
      wr_en   = s1_adv && s1_flags.has_col0;
      wr_addr = s1_col - COLW'(1);
      wr_data = '{older: line0.newer, newer: s1_blur0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      q_count <= '0;
    end else begin
      pend <= s1_adv && s1_flags.has_col0 && s1_flags.row_end;
      if (load) begin
        q_count <= n_results;
      end else if (out_fire) begin
        q_count <= q_count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pend_addr <= s1_col;
      pend_data <= '{older: line1.newer, newer: s1_blur1};
    end
    if (load) begin
      queue <= slots;
    end else if (out_fire) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
      queue[2] <= queue[3];
    end
  end

endmodule
`default_nettype wire

>>> design/rgbblur_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgbblur_checker
// port level checks on the blur top level, bound to it
// ---------------------------------------------------------------------------
module rgbblur_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result changed");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  // results of one pixel leave without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a run of results");

endmodule

bind rgb_separable_box_blur_3x3 rgbblur_checker u_rgbblur_checker (.*);
`default_nettype wire
